// File: hdl/double_hash_int_map_defines.svh
// assertion macros shared by the hash map rtl
// no dependencies; taken in by the top level
`ifndef DOUBLE_HASH_INT_MAP_DEFINES_SVH
`define DOUBLE_HASH_INT_MAP_DEFINES_SVH

// checked only outside reset
`define DHIM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define DHIM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/dhim_pkg.sv
// shared types and codes of the double hashing key/value table
// no dependencies; used by the interfaces, the top module and the bench
`default_nettype none

package dhim_pkg;

  localparam int unsigned KEY_W   = 31;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COUNT_W = 10;

  localparam logic [DATA_W-1:0] MINUS_ONE = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    FUNC_GET    = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_REMOVE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    STAT_FOUND  = 2'd0,
    STAT_ABSENT = 2'd1,
    STAT_REJECT = 2'd2,
    STAT_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    TAG_NEVER = 2'd0,
    TAG_LIVE  = 2'd1,
    TAG_TOMB  = 2'd2
  } tag_e;

  // one slot of the table memory
  typedef struct packed {
    tag_e              tag;
    logic [KEY_W-1:0]  key;
    logic [DATA_W-1:0] value;
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/dhim_if.sv
// request and response channels of the hash map, valid/ready handshake
// depends on dhim_pkg for field widths
`default_nettype none

interface dhim_req_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic signed [dhim_pkg::DATA_W-1:0]  key;
  logic signed [dhim_pkg::DATA_W-1:0]  value;

  modport source (output valid, output func, output key, output value, input ready);
  modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface dhim_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic signed [dhim_pkg::DATA_W-1:0]  value_out;
  logic [dhim_pkg::COUNT_W-1:0]        count;

  modport source (output valid, output status, output value_out, output count, input ready);
  modport sink   (input valid, input status, input value_out, input count, output ready);
endinterface

`default_nettype wire

// File: hdl/dhim_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
`default_nettype none

module dhim_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: hdl/double_hash_int_map.sv
// channel | dir | handshake          | word
// --------+-----+--------------------+------------------------------
// req_i   | in  | req_i.valid/ready  | func, key, value
// rsp_o   | out | rsp_o.valid/ready  | status, value_out, count
//
// an item runs through hashing in ST_HASH1, ST_HASH2 and ST_HASH3, then one ram
// read per probed slot (none for a rejected add, else 1..CAPACITY slots), then
// back to the idle state.
// the probe loop over the single slot ram sets the rate, one probe per cycle.
// after reset the ram is swept slot by slot to mark every slot never used;
// no word is taken during the sweep.
// a full result register lets the next word in; the probe, or a rejected add
// in ST_HASH3, stalls only while a new result is due and the last is not taken.
// depends on dhim_pkg, dhim_if, dhim_ram and double_hash_int_map_defines.svh
`default_nettype none
`include "double_hash_int_map_defines.svh"

module double_hash_int_map #(
  parameter int unsigned CAPACITY = 1021
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  dhim_req_if.sink   req_i,
  dhim_rsp_if.source rsp_o
);

  localparam int unsigned IDX_W  = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);
  localparam int unsigned EXT_W  = (CNT_W > dhim_pkg::COUNT_W) ? CNT_W : dhim_pkg::COUNT_W;
  localparam int unsigned KEY_W  = dhim_pkg::KEY_W;
  localparam int unsigned DATA_W = dhim_pkg::DATA_W;
  localparam int unsigned ENT_W  = $bits(dhim_pkg::entry_t);

  // floor(2^32 / divisor): quotient estimate is low by at most one
  localparam logic [31:0] RECIP_H = 32'((64'd1 << 32) / CAPACITY);
  localparam logic [31:0] RECIP_S = 32'((64'd1 << 32) / (CAPACITY - 1));
  localparam logic [31:0] CAP_32  = 32'(CAPACITY);
  localparam logic [31:0] CAPM_32 = 32'(CAPACITY - 1);
  localparam logic [IDX_W:0]   CAP_X   = (IDX_W + 1)'(CAPACITY);
  localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(CAPACITY - 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_HASH1 = 6'b000100,
    ST_HASH2 = 6'b001000,
    ST_HASH3 = 6'b010000,
    ST_PROBE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // control registers
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] pcnt_q, pcnt_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic             out_valid_q, out_valid_d;

  // payload registers
  logic              is_add_q, is_rem_q, neg_q;
  logic [KEY_W-1:0]  m_q;
  logic [DATA_W-1:0] value_q;
  logic [KEY_W-1:0]  qh_q, qs_q;
  logic [31:0]       rh_q, rs_q;
  logic [IDX_W-1:0]  step_q;
  logic [1:0]                   out_status_q;
  logic [DATA_W-1:0]            out_value_q;
  logic [dhim_pkg::COUNT_W-1:0] out_count_q;

  // datapath nets
  logic [62:0]       prod_h, prod_s;
  logic [31:0]       qc_h, qc_s, rh_raw, rs_raw;
  logic [31:0]       home_w, stepm_w;
  logic [IDX_W:0]    sum_w;
  logic [IDX_W-1:0]  next_idx;
  logic              out_free;
  logic              req_fire;

  // finishing step
  logic                  fin;
  logic                  fin_load;
  dhim_pkg::status_e     fin_status;
  logic [DATA_W-1:0]     fin_value;
  logic [EXT_W-1:0]      cnt_ext;

  // ram port
  logic                  mem_we, mem_re;
  logic [IDX_W-1:0]      mem_waddr, mem_raddr;
  dhim_pkg::entry_t      mem_wdata, rd;
  logic [ENT_W-1:0]      mem_rdata;

  logic hit_never, hit_key, last_probe;

  dhim_ram #(
    .WIDTH (ENT_W),
    .DEPTH (CAPACITY)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign rd = dhim_pkg::entry_t'(mem_rdata);

  assign req_i.ready = (state_q == ST_IDLE);
  assign req_fire    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  // hashing arithmetic
  assign prod_h  = {32'd0, m_q} * {31'd0, RECIP_H};
  assign prod_s  = {32'd0, m_q} * {31'd0, RECIP_S};
  assign qc_h    = {1'b0, qh_q} * CAP_32;
  assign qc_s    = {1'b0, qs_q} * CAPM_32;
  assign rh_raw  = {1'b0, m_q} - qc_h;
  assign rs_raw  = {1'b0, m_q} - qc_s;
  assign home_w  = (rh_q >= CAP_32) ? (rh_q - CAP_32) : rh_q;
  assign stepm_w = (rs_q >= CAPM_32) ? (rs_q - CAPM_32) : rs_q;

  // next probe position, step stays below capacity
  assign sum_w    = {1'b0, idx_q} + {1'b0, step_q};
  assign next_idx = (sum_w >= CAP_X) ? IDX_W'(sum_w - CAP_X) : sum_w[IDX_W-1:0];

  assign hit_never  = (rd.tag == dhim_pkg::TAG_NEVER);
  assign hit_key    = (rd.tag == dhim_pkg::TAG_LIVE) && !neg_q && (rd.key == m_q);
  assign last_probe = (pcnt_q == IDX_TOP);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    pcnt_d      = pcnt_q;
    live_d      = live_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    fin         = 1'b0;
    fin_status  = dhim_pkg::STAT_ABSENT;
    fin_value   = dhim_pkg::MINUS_ONE;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = idx_q;

    unique case (state_q)
      ST_CLEAR: begin
        // sweep: every slot marked never used
        mem_we = 1'b1;
        if (idx_q == IDX_TOP) begin
          idx_d   = '0;
          state_d = ST_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_HASH1;
        end
      end
      ST_HASH1: begin
        state_d = ST_HASH2;
      end
      ST_HASH2: begin
        state_d = ST_HASH3;
      end
      ST_HASH3: begin
        if (is_add_q && neg_q) begin
          fin        = 1'b1;
          fin_status = dhim_pkg::STAT_REJECT;
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = home_w[IDX_W-1:0];
          idx_d     = home_w[IDX_W-1:0];
          pcnt_d    = '0;
          state_d   = ST_PROBE;
        end
      end
      ST_PROBE: begin
        if (hit_key) begin
          fin        = 1'b1;
          fin_status = dhim_pkg::STAT_FOUND;
          fin_value  = rd.value;
          if (out_free) begin
            if (is_add_q) begin
              mem_we    = 1'b1;
              mem_wdata = '{tag: dhim_pkg::TAG_LIVE, key: rd.key, value: value_q};
            end else if (is_rem_q) begin
              mem_we    = 1'b1;
              mem_wdata = '{tag: dhim_pkg::TAG_TOMB, key: rd.key, value: rd.value};
              live_d    = live_q - 1'b1;
            end
          end
        end else if (hit_never) begin
          fin = 1'b1;
          if (out_free && is_add_q) begin
            mem_we    = 1'b1;
            mem_wdata = '{tag: dhim_pkg::TAG_LIVE, key: m_q, value: value_q};
            live_d    = live_q + 1'b1;
          end
        end else if (last_probe) begin
          // every slot visited without a free one
          fin = 1'b1;
          if (is_add_q) begin
            fin_status = dhim_pkg::STAT_FULL;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = next_idx;
          idx_d     = next_idx;
          pcnt_d    = pcnt_q + 1'b1;
        end
        if (fin && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
        idx_d   = '0;
      end
    endcase

    fin_load = fin && out_free;
    if (fin_load) begin
      out_valid_d = 1'b1;
    end
  end

  assign cnt_ext = EXT_W'(live_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      pcnt_q      <= '0;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      pcnt_q      <= pcnt_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      is_add_q <= (req_i.func == dhim_pkg::FUNC_ADD);
      is_rem_q <= (req_i.func == dhim_pkg::FUNC_REMOVE);
      neg_q    <= req_i.key[DATA_W-1];
      m_q      <= req_i.key[KEY_W-1:0];
      value_q  <= req_i.value;
    end
    if (state_q == ST_HASH1) begin
      qh_q <= prod_h[62:32];
      qs_q <= prod_s[62:32];
    end
    if (state_q == ST_HASH2) begin
      rh_q <= rh_raw;
      rs_q <= rs_raw;
    end
    if (state_q == ST_HASH3) begin
      step_q <= IDX_W'(stepm_w + 32'd1);
    end
    if (fin_load) begin
      out_status_q <= fin_status;
      out_value_q  <= fin_value;
      out_count_q  <= cnt_ext[dhim_pkg::COUNT_W-1:0];
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.status    = out_status_q;
  assign rsp_o.value_out = out_value_q;
  assign rsp_o.count     = out_count_q;

  `DHIM_ASSERT(a_live_moves_on_result, clk_i, rst_ni,
    !$stable(live_q) |-> $past(fin_load), "live count changed without a result")
  `DHIM_ASSERT(a_result_from_finish, clk_i, rst_ni,
    $rose(out_valid_q) |-> ($past(state_q == ST_PROBE) || $past(state_q == ST_HASH3)),
    "result raised outside the probe")
  `DHIM_ASSERT_ALWAYS(a_probe_in_range, clk_i,
    (state_q == ST_PROBE) |-> (idx_q <= IDX_TOP), "probe index beyond capacity")

endmodule

`default_nettype wire

// File: test/tb_top.sv
// self-checking bench for the double hashing key/value table
// needs dhim_pkg, dhim_req_if / dhim_rsp_if and double_hash_int_map from the rtl
`default_nettype none

module tb_top;
  import dhim_pkg::*;

  localparam int unsigned CAPACITY    = 1021;
  localparam int          HOLD_CYCLES = 300;
  localparam int          IDLE_LIMIT  = 10000;
  localparam int          PHASE_ITEMS = 40;
  localparam logic [1:0]  FUNC_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value_out;
    logic [9:0]  count;
  } answer_t;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
    logic        typed;
    answer_t     answer;
  } request_row_t;

  logic clk_i;
  logic rst_ni;

  dhim_req_if req_if ();
  dhim_rsp_if rsp_if ();

  double_hash_int_map #(.CAPACITY(CAPACITY)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // shadow copy of the table
  tag_e        slot_tag   [CAPACITY];
  logic [30:0] slot_key   [CAPACITY];
  logic [31:0] slot_value [CAPACITY];
  int unsigned live_entries;
  int unsigned never_left;

  answer_t     due_answers [$];
  logic [31:0] stored_keys [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit pressure_req;
  bit pressure_taken;
  int sent;
  int checked;
  int errors;
  int full_seen;

  // typed answers follow the table contents row by row, starting empty
  request_row_t directed_rows [23] = '{
    '{FUNC_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd0}},
    '{FUNC_ADD,    32'hFFFF_FFFF, 32'h0000_0005, 1'b1, '{STAT_REJECT, MINUS_ONE, 10'd0}},
    '{FUNC_ADD,    32'h8000_0000, 32'h0000_0000, 1'b1, '{STAT_REJECT, MINUS_ONE, 10'd0}},
    '{FUNC_ADD,    32'h0000_0000, 32'h7FFF_FFFF, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd1}},
    '{FUNC_ADD,    32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd2}},
    '{FUNC_GET,    32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, '{STAT_FOUND, 32'h8000_0000, 10'd2}},
    '{FUNC_ADD,    32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{STAT_FOUND, 32'h7FFF_FFFF, 10'd2}},
    '{FUNC_GET,    32'h8000_0000, 32'h0000_0000, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd2}},
    '{FUNC_REMOVE, 32'h8000_0000, 32'h0000_0000, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd2}},
    '{FUNC_SPARE,  32'h0000_0000, 32'h0000_0000, 1'b1, '{STAT_FOUND, 32'hFFFF_FFFF, 10'd2}},
    '{FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{STAT_FOUND, 32'hFFFF_FFFF, 10'd1}},
    '{FUNC_GET,    32'h0000_0000, 32'h0000_0000, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd1}},
    '{FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd1}},
    '{FUNC_ADD,    32'd1021,      32'h1234_5678, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd2}},
    '{FUNC_ADD,    32'd2042,      32'h0BAD_F00D, 1'b1, '{STAT_ABSENT, MINUS_ONE, 10'd3}},
    '{FUNC_GET,    32'd1021,      32'h0000_0000, 1'b1, '{STAT_FOUND, 32'h1234_5678, 10'd3}},
    '{FUNC_GET,    32'd3063,      32'h0000_0000, 1'b0, '0},
    '{FUNC_REMOVE, 32'd2042,      32'h0000_0000, 1'b0, '0},
    '{FUNC_ADD,    32'd2042,      32'h55AA_55AA, 1'b0, '0},
    '{FUNC_ADD,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{FUNC_REMOVE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
    '{FUNC_SPARE,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, '0},
    '{FUNC_GET,    32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0}
  };

  // walks the probe sequence of one request and updates the shadow table
  function automatic answer_t probe_table(logic [1:0] f, logic [31:0] k, logic [31:0] v);
    answer_t     a;
    logic [30:0] m;
    int unsigned j;
    int unsigned step;
    int unsigned found_at;
    int unsigned free_at;
    bit          found;
    bit          has_free;
    a.status    = STAT_ABSENT;
    a.value_out = MINUS_ONE;
    found       = 1'b0;
    has_free    = 1'b0;
    found_at    = 0;
    free_at     = 0;
    if (f == FUNC_ADD && k[31]) begin
      a.status = STAT_REJECT;
    end else begin
      m    = k[30:0];
      j    = m % CAPACITY;
      step = 1 + m % (CAPACITY - 1);
      for (int unsigned i = 0; i < CAPACITY; i++) begin
        if (slot_tag[j] == TAG_NEVER) begin
          has_free = 1'b1;
          free_at  = j;
          break;
        end
        // negative keys never match, stored keys are all non-negative
        if (slot_tag[j] == TAG_LIVE && !k[31] && slot_key[j] == m) begin
          found    = 1'b1;
          found_at = j;
          break;
        end
        j += step;
        if (j >= CAPACITY) j -= CAPACITY;
      end
      if (found) begin
        a.status    = STAT_FOUND;
        a.value_out = slot_value[found_at];
        if (f == FUNC_ADD) begin
          slot_value[found_at] = v;
        end else if (f == FUNC_REMOVE) begin
          slot_tag[found_at] = TAG_TOMB;
          if (live_entries > 0) live_entries--;
        end
      end else if (f == FUNC_ADD) begin
        if (has_free) begin
          slot_tag[free_at]   = TAG_LIVE;
          slot_key[free_at]   = m;
          slot_value[free_at] = v;
          live_entries++;
          never_left--;
        end else begin
          a.status = STAT_FULL;
        end
      end
    end
    a.count = live_entries[9:0];
    return a;
  endfunction

  // mix of known keys, colliding keys, extremes, negatives and noise
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 40 && stored_keys.size() > 0)
      return stored_keys[$urandom_range(stored_keys.size() - 1)];
    else if (r < 55)
      return $urandom_range(3000) * CAPACITY + $urandom_range(3);
    else if (r < 75)
      return $urandom() & 32'h7FFF_FFFF;
    else if (r < 85)
      return $urandom() | 32'h8000_0000;
    else if (r < 90)
      case ($urandom_range(3))
        0:       return 32'h0000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h8000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    else
      return $urandom_range(63);
  endfunction

  task automatic send_word(input logic [1:0] f, input logic [31:0] k, input logic [31:0] v,
                           input bit typed, input answer_t typed_answer);
    answer_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.func  <= f;
    req_if.key   <= k;
    req_if.value <= v;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    predicted = probe_table(f, k, v);
    due_answers.push_back(typed ? typed_answer : predicted);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic random_phase(input int n);
    logic [1:0]  f;
    logic [31:0] k;
    int          r;
    repeat (n) begin
      r = $urandom_range(99);
      if (r < 45)      f = FUNC_ADD;
      else if (r < 75) f = FUNC_GET;
      else if (r < 95) f = FUNC_REMOVE;
      else             f = FUNC_SPARE;
      k = pick_key();
      send_word(f, k, $urandom(), 1'b0, '0);
      if (f == FUNC_ADD && !k[31]) stored_keys.push_back(k);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin : rsp_ready_drive
    int hold;
    hold = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      // long hold-off so the result register fills and the request side stalls
      if (pressure_req && !pressure_taken) begin
        pressure_taken = 1'b1;
        hold = HOLD_CYCLES;
      end
      if (hold > 0) begin
        hold--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (rsp_if.status == STAT_FULL) full_seen++;
      if (due_answers.size() == 0) begin
        $display("%0t unexpected word: status %0d value_out %h count %0d", $time,
                 rsp_if.status, rsp_if.value_out, rsp_if.count);
        errors++;
      end else begin
        want = due_answers.pop_front();
        checked++;
        if (rsp_if.status !== want.status) begin
          $display("%0t status mismatch: expected %0d, actual %0d", $time,
                   want.status, rsp_if.status);
          errors++;
        end
        if (rsp_if.value_out !== want.value_out) begin
          $display("%0t value_out mismatch: expected %h, actual %h", $time,
                   want.value_out, rsp_if.value_out);
          errors++;
        end
        if (rsp_if.count !== want.count) begin
          $display("%0t count mismatch: expected %0d, actual %0d", $time,
                   want.count, rsp_if.count);
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    req_if.valid   = 1'b0;
    req_if.func    = FUNC_GET;
    req_if.key     = '0;
    req_if.value   = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    pressure_req   = 1'b0;
    pressure_taken = 1'b0;
    sent           = 0;
    checked        = 0;
    errors         = 0;
    full_seen      = 0;
    live_entries   = 0;
    never_left     = CAPACITY;
    for (int i = 0; i < CAPACITY; i++) begin
      slot_tag[i]   = TAG_NEVER;
      slot_key[i]   = '0;
      slot_value[i] = '0;
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].func, directed_rows[i].key, directed_rows[i].value,
                directed_rows[i].typed, directed_rows[i].answer);

    pressure_req = 1'b1;
    random_phase(PHASE_ITEMS);
    send_idle_pct = 48;
    random_phase(PHASE_ITEMS);
    send_idle_pct  = 0;
    recv_stall_pct = 48;
    random_phase(PHASE_ITEMS);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    random_phase(PHASE_ITEMS);

    // use up every never-used slot, then hit the full table
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (never_left > 0)
      send_word(FUNC_ADD, $urandom() & 32'h7FFF_FFFF, $urandom(), 1'b0, '0);
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    repeat (6) send_word(FUNC_ADD, $urandom() & 32'h7FFF_FFFF, $urandom(), 1'b0, '0);
    random_phase(14);
    req_if.valid <= 1'b0;

    while (due_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);

    $display("summary: %0d requests, %0d answers checked, %0d mismatches", sent, checked,
             errors);
    $display("summary: rejects, replaces, tombstones, pressure stall and %0d full-table answers",
             full_seen);
    if (errors == 0 && due_answers.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/dhim_pkg.sv
hdl/dhim_if.sv
hdl/dhim_ram.sv
hdl/double_hash_int_map.sv
test/tb_top.sv
